// ===== sv/usrh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usrh_pkg
// shared constants and codes of the usb standard request handler
// ----------------------------------------------------------------------------
package usrh_pkg;

  // endpoint table size, endpoint zero included
  localparam int MAX_ENDPOINTS = 16;
  localparam int EP_W          = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1;

  // field widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int EP_CNT_W   = 5;
  localparam int ADDR_W     = 7;
  localparam int WORD_W     = 16;

  // device states on the bus
  typedef enum logic [2:0] {
    DevDetached   = 3'd0,
    DevAttached   = 3'd1,
    DevPowered    = 3'd2,
    DevDefault    = 3'd3,
    DevAddress    = 3'd4,
    DevConfigured = 3'd5,
    DevSuspended  = 3'd6
  } dev_state_e;

  // result outcome codes
  typedef enum logic [2:0] {
    OutStall   = 3'd0,
    OutData    = 3'd1,
    OutStatus  = 3'd2,
    OutAddress = 3'd3,
    OutConfig  = 3'd4,
    OutWakeup  = 3'd5,
    OutForward = 3'd6
  } outcome_e;

  // bRequest codes handled here
  localparam logic [7:0] ReqGetStatus    = 8'd0;
  localparam logic [7:0] ReqClearFeature = 8'd1;
  localparam logic [7:0] ReqSetFeature   = 8'd3;
  localparam logic [7:0] ReqSetAddress   = 8'd5;
  localparam logic [7:0] ReqGetConfig    = 8'd8;
  localparam logic [7:0] ReqSetConfig    = 8'd9;

  // recipient field of bmRequestType
  localparam logic [4:0] RcpDevice    = 5'd0;
  localparam logic [4:0] RcpInterface = 5'd1;
  localparam logic [4:0] RcpEndpoint  = 5'd2;

  // feature selectors
  localparam logic [15:0] FeatEndpointHalt = 16'd0;
  localparam logic [15:0] FeatRemoteWakeup = 16'd1;

  // item kinds
  localparam logic KindSetup  = 1'b0;
  localparam logic KindForced = 1'b1;

  // forced state code with no meaning
  localparam logic [2:0] ForcedIgnore = 3'd7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CfgEndpointCount = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CfgWakeupCapable = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CfgSelfPowered   = 2'd2;

endpackage : usrh_pkg
`default_nettype wire

// ===== sv/usb_standard_request_handler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usb_standard_request_handler
// chapter 9 standard request decoder with device state, address,
// configuration, remote wakeup and endpoint halt bookkeeping
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ------------------------------
//  in        sink       in_valid_i / in_stall_o    kind, setup fields, forced state
//  out       source     out_valid_o / out_stall_i  outcome, reply, address, flags
//  cfg       sink       cfg_we_i                   cfg_index_i, cfg_data_i
//
//  one request per cycle unless stalled: the request is decoded against the
//  current state in a single combinational pass and the result lands in the
//  output register at the accepting edge, together with the state update
//  a result appears in the cycle after its request is accepted and holds
//  while out_stall_i is high; a new request is taken whenever the output
//  register is empty or being drained in the same cycle
//  reset brings the device to detached, address and configuration zero,
//  remote wakeup off and all endpoint halt bits clear
//
module usb_standard_request_handler (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // request channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            kind_i,
  input  wire logic [7:0]                      request_type_i,
  input  wire logic [7:0]                      request_code_i,
  input  wire logic [15:0]                     value_word_i,
  input  wire logic [15:0]                     index_word_i,
  input  wire logic [15:0]                     length_word_i,
  input  wire logic [2:0]                      forced_state_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [2:0]                           outcome_o,
  output logic [15:0]                          reply_data_o,
  output logic [1:0]                           reply_length_o,
  output logic [6:0]                           new_address_o,
  output logic [3:0]                           changed_endpoint_o,
  output logic                                 clear_rx_queues_o,
  output logic                                 clear_tx_queues_o,
  // configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [usrh_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [usrh_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import usrh_pkg::*;

  localparam logic [EP_CNT_W-1:0] EpLimit = EP_CNT_W'(MAX_ENDPOINTS);

  // configuration registers
  logic [EP_CNT_W-1:0] ep_count_q;
  logic                wakeup_capable_q;
  logic                self_powered_q;

  // device state
  dev_state_e               state_q, state_d;
  logic [ADDR_W-1:0]        addr_q, addr_d;
  logic                     cfg_num_q, cfg_num_d;
  logic                     wakeup_en_q, wakeup_en_d;
  logic [MAX_ENDPOINTS-1:0] halted_q, halted_d;

  // output register
  logic              out_valid_q;
  outcome_e          outcome_q, outcome_d;
  logic [WORD_W-1:0] data_q, data_d;
  logic [1:0]        len_q, len_d;
  logic [3:0]        chg_q, chg_d;
  logic              rx_q, rx_d;
  logic              tx_q, tx_d;

  logic in_accept;

  // request decode
  logic [4:0]          recip;
  logic [6:0]          ep_idx;
  logic [EP_CNT_W-1:0] ep_lim;
  logic                ep_ok;
  logic [EP_W-1:0]     ep_num;
  logic                ep_nonzero;
  logic                addr_ep_block;
  logic                state_changed;

  // skid-free output stage: stall only when a held result is not taken
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign recip  = request_type_i[4:0];
  assign ep_idx = index_word_i[6:0];
  assign ep_lim = (ep_count_q < EpLimit) ? ep_count_q : EpLimit;
  // direction bit dropped, number must be below the endpoint limit
  assign ep_ok      = ep_idx < 7'(ep_lim);
  assign ep_num     = ep_idx[EP_W-1:0];
  assign ep_nonzero = ep_idx != 7'd0;
  // in address state only endpoint zero, with the index word all zero, may be addressed
  assign addr_ep_block = (state_q == DevAddress) && (index_word_i != 16'd0);

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    cfg_num_d   = cfg_num_q;
    wakeup_en_d = wakeup_en_q;
    halted_d    = halted_q;
    outcome_d   = OutStall;
    data_d      = '0;
    len_d       = '0;
    chg_d       = '0;

    if (kind_i == KindForced) begin
      if (forced_state_i != ForcedIgnore) begin
        state_d = dev_state_e'(forced_state_i);
      end
      outcome_d = OutStatus;
    end else begin
      case (request_code_i)
        ReqGetStatus: begin
          if (value_word_i == 16'd0 && length_word_i == 16'd2 && state_q != DevDefault) begin
            if (recip == RcpDevice) begin
              data_d    = {14'd0, wakeup_en_q, self_powered_q};
              outcome_d = OutData;
              len_d     = 2'd2;
            end else if (recip == RcpInterface) begin
              if (state_q == DevConfigured) begin
                outcome_d = OutData;
                len_d     = 2'd2;
              end
            end else if (recip == RcpEndpoint) begin
              if (!addr_ep_block && ep_ok) begin
                data_d    = {15'd0, halted_q[ep_num]};
                outcome_d = OutData;
                len_d     = 2'd2;
              end
            end
          end
        end
        ReqClearFeature, ReqSetFeature: begin
          // clear needs configured, set only excludes default
          if (length_word_i == 16'd0 &&
              ((request_code_i == ReqClearFeature) ? (state_q == DevConfigured)
                                                   : (state_q != DevDefault))) begin
            if (recip == RcpDevice) begin
              if (value_word_i == FeatRemoteWakeup) begin
                if (request_code_i == ReqClearFeature) begin
                  if (wakeup_capable_q) begin
                    wakeup_en_d = 1'b0;
                    outcome_d   = OutWakeup;
                  end
                end else begin
                  // not capable: acknowledged, bit left alone
                  if (wakeup_capable_q) begin
                    wakeup_en_d = 1'b1;
                  end
                  outcome_d = OutWakeup;
                end
              end
            end else if (recip == RcpEndpoint) begin
              if (!addr_ep_block && ep_ok && ep_nonzero &&
                  value_word_i == FeatEndpointHalt) begin
                halted_d[ep_num] = (request_code_i == ReqSetFeature);
                chg_d            = 4'(ep_num);
                outcome_d        = OutStatus;
              end
            end
          end
        end
        ReqSetAddress: begin
          if (value_word_i[15:7] == '0 && index_word_i == 16'd0 &&
              length_word_i == 16'd0 && state_q < DevConfigured) begin
            addr_d    = value_word_i[6:0];
            state_d   = (value_word_i[6:0] == 7'd0) ? DevDefault : DevAddress;
            outcome_d = OutAddress;
          end
        end
        ReqGetConfig: begin
          if (value_word_i == 16'd0 && index_word_i == 16'd0 &&
              length_word_i == 16'd1 && state_q != DevDefault) begin
            data_d    = {15'd0, cfg_num_q};
            len_d     = 2'd1;
            outcome_d = OutData;
          end
        end
        ReqSetConfig: begin
          if (index_word_i == 16'd0 && length_word_i == 16'd0 &&
              state_q != DevDefault && value_word_i[15:1] == '0) begin
            cfg_num_d = value_word_i[0];
            state_d   = value_word_i[0] ? DevConfigured : DevAddress;
            outcome_d = OutConfig;
          end
        end
        default: begin
          outcome_d = OutForward;
        end
      endcase
    end

    // queue flags follow every state change: leaving configured flushes both
    // directions, entering configured flushes receive
    state_changed = state_d != state_q;
    rx_d = state_changed && (state_q == DevConfigured || state_d == DevConfigured);
    tx_d = state_changed && (state_q == DevConfigured);
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ep_count_q       <= EP_CNT_W'(1);
      wakeup_capable_q <= 1'b0;
      self_powered_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgEndpointCount: ep_count_q       <= cfg_data_i[EP_CNT_W-1:0];
        CfgWakeupCapable: wakeup_capable_q <= cfg_data_i[0];
        CfgSelfPowered:   self_powered_q   <= cfg_data_i[0];
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

  // device state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= DevDetached;
      addr_q      <= '0;
      cfg_num_q   <= 1'b0;
      wakeup_en_q <= 1'b0;
      halted_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        state_q     <= state_d;
        addr_q      <= addr_d;
        cfg_num_q   <= cfg_num_d;
        wakeup_en_q <= wakeup_en_d;
        halted_q    <= halted_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with each request
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      outcome_q <= outcome_d;
      data_q    <= data_d;
      len_q     <= len_d;
      chg_q     <= chg_d;
      rx_q      <= rx_d;
      tx_q      <= tx_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign outcome_o          = outcome_q;
  assign reply_data_o       = data_q;
  assign reply_length_o     = len_q;
  // address register already holds the value after the request
  assign new_address_o      = addr_q;
  assign changed_endpoint_o = chg_q;
  assign clear_rx_queues_o  = rx_q;
  assign clear_tx_queues_o  = tx_q;

  // a transmit flush only comes with leaving configured, which also flushes receive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && tx_q |-> rx_q)
    else $error("transmit flush without receive flush");

  // refused or forwarded requests change nothing and reply nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (outcome_q == OutStall || outcome_q == OutForward) |->
      len_q == 2'd0 && chg_q == 4'd0 && !rx_q && data_q == '0)
    else $error("stall or forward result carries a reply or a flag");

  // endpoint zero can never be halted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !halted_q[0])
    else $error("endpoint zero halt bit set");

  // a halt change names a nonzero endpoint and leaves the device state alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && chg_d != 4'd0 |=> $stable(state_q) && outcome_q == OutStatus)
    else $error("endpoint halt change with a state change");

endmodule : usb_standard_request_handler
`default_nettype wire
